// File: hdl/aabb_plane_set_cull_top_defines.svh
// ----------------------------------------------------------------------------
// Plane set cull assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AABB_PLANE_SET_CULL_TOP_DEFINES_SVH
`define AABB_PLANE_SET_CULL_TOP_DEFINES_SVH

// Same-cycle implication
`define APSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication starting in the next cycle
`define APSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication with a free-form consequent sequence
`define APSC_ASSERT_SEQ(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

// File: hdl/apsc_pkg.sv
// ----------------------------------------------------------------------------
// Plane set cull package
// Box and plane types, per-plane verdict and shared helpers.
// ----------------------------------------------------------------------------
package apsc_pkg;

    localparam int REG_COUNT      = 6;
    localparam int NUM_PLANES_DEF = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam int COORD_W  = 16;
    localparam int EXTENT_W = 15;
    localparam int NORM_W   = 16;

    // Normal products and the scaled offset carry 14 fraction bits
    localparam int PROD_W   = 2 * COORD_W;
    localparam int OFFS_W   = NORM_W + 14;
    localparam int RPROD_W  = EXTENT_W + NORM_W;
    localparam int DIST_W   = PROD_W + 2;
    localparam int RADIUS_W = RPROD_W + 2;
    localparam int MARGIN_W = DIST_W + 1;

    typedef struct packed {
        logic signed [NORM_W-1:0] d;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [EXTENT_W-1:0]       ex;
        logic [EXTENT_W-1:0]       ey;
        logic [EXTENT_W-1:0]       ez;
    } box_t;

    typedef struct packed {
        logic outside;
        logic enclosed;
    } verdict_t;

    // Magnitude of a normal component; the most negative code maps to 2.0
    function automatic logic [NORM_W-1:0] norm_mag(input logic signed [NORM_W-1:0] n);
        logic [NORM_W-1:0] m;
        m = n[NORM_W-1] ? (~n + 1'b1) : n;
        return m;
    endfunction

endpackage

// File: hdl/apsc_plane_lane.sv
// ----------------------------------------------------------------------------
// Plane set cull lane
// Three-stage test of one box against one plane: products, sums, compares.
// ----------------------------------------------------------------------------
module apsc_plane_lane (
    input  logic              clk,
    input  apsc_pkg::box_t    box,
    input  apsc_pkg::plane_t  plane,
    output apsc_pkg::verdict_t verdict
);

    logic signed [apsc_pkg::PROD_W-1:0]   px_reg, py_reg, pz_reg;
    logic signed [apsc_pkg::OFFS_W-1:0]   pd_reg;
    logic        [apsc_pkg::RPROD_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [apsc_pkg::DIST_W-1:0]   dist_reg;
    logic        [apsc_pkg::RADIUS_W-1:0] radius_reg;
    logic signed [apsc_pkg::DIST_W-1:0]   radius_s;
    logic signed [apsc_pkg::MARGIN_W-1:0] margin;
    apsc_pkg::verdict_t                   verdict_next;
    apsc_pkg::verdict_t                   verdict_reg;

    // Stage 1: products
    always_ff @(posedge clk)
    begin
        px_reg <= plane.nx * box.cx;
        py_reg <= plane.ny * box.cy;
        pz_reg <= plane.nz * box.cz;
        pd_reg <= {plane.d, 14'b0};
        rx_reg <= box.ex * apsc_pkg::norm_mag(plane.nx);
        ry_reg <= box.ey * apsc_pkg::norm_mag(plane.ny);
        rz_reg <= box.ez * apsc_pkg::norm_mag(plane.nz);
    end

    // Stage 2: distance and projected radius
    always_ff @(posedge clk)
    begin
        dist_reg <= apsc_pkg::DIST_W'(px_reg) + apsc_pkg::DIST_W'(py_reg)
                  + apsc_pkg::DIST_W'(pz_reg) + apsc_pkg::DIST_W'(pd_reg);
        radius_reg <= apsc_pkg::RADIUS_W'(rx_reg) + apsc_pkg::RADIUS_W'(ry_reg)
                    + apsc_pkg::RADIUS_W'(rz_reg);
    end

    // Stage 3: outside when dist > radius, inside when dist + radius < 0
    always_comb
    begin
        radius_s              = $signed({1'b0, radius_reg});
        margin                = apsc_pkg::MARGIN_W'(dist_reg) + apsc_pkg::MARGIN_W'(radius_s);
        verdict_next.outside  = (dist_reg > radius_s);
        verdict_next.enclosed = margin[apsc_pkg::MARGIN_W-1];
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign verdict = verdict_reg;

endmodule

// File: hdl/aabb_plane_set_cull_top.sv
// ----------------------------------------------------------------------------
// Plane set cull top level
// Tests a center/extent box against a set of stored planes, one box per clock.
// ----------------------------------------------------------------------------
// A box request is taken on every clock where start is high; busy is always
// low, so boxes may stream back to back at one per cycle. The answer for a
// request appears on visible and fully_inside, with done high for a single
// cycle; the receiver must take it then. The answer passes through the
// register stages of the per-plane lanes (products, sums, compares) and then
// the registered reduction across planes. Planes are loaded via
// cfg_we/cfg_index/cfg_data and should only change while no box is in flight.
module aabb_plane_set_cull_top #(
    parameter int NUM_PLANES = apsc_pkg::NUM_PLANES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [15:0]              center_x,
    input  logic signed [15:0]              center_y,
    input  logic signed [15:0]              center_z,
    input  logic [14:0]                     extent_x,
    input  logic [14:0]                     extent_y,
    input  logic [14:0]                     extent_z,
    input  logic                            cfg_we,
    input  logic [apsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic                            visible,
    output logic                            fully_inside
);

`include "aabb_plane_set_cull_top_defines.svh"

    localparam int EVAL_PLANES = (NUM_PLANES < apsc_pkg::REG_COUNT) ?
                                 NUM_PLANES : apsc_pkg::REG_COUNT;
    localparam int LANE_STAGES = 3;

    apsc_pkg::plane_t   plane_reg [apsc_pkg::REG_COUNT];
    apsc_pkg::box_t     box;
    apsc_pkg::verdict_t lane_verdict [EVAL_PLANES];
    logic [LANE_STAGES-1:0] valid_reg;
    logic done_reg;
    logic visible_reg, visible_next;
    logic inside_reg, inside_next;
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Plane registers; out-of-range indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apsc_pkg::REG_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < apsc_pkg::CFG_IDX_W'(apsc_pkg::REG_COUNT)))
        begin
            plane_reg[cfg_index] <= apsc_pkg::plane_t'(cfg_data);
        end
    end

    assign box = '{cx: center_x, cy: center_y, cz: center_z,
                   ex: extent_x, ey: extent_y, ez: extent_z};

    for (genvar g = 0; g < EVAL_PLANES; g++)
    begin : g_lane
        apsc_plane_lane u_lane (
            .clk     (clk),
            .box     (box),
            .plane   (plane_reg[g]),
            .verdict (lane_verdict[g])
        );
    end

    // Valid bits follow the lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[LANE_STAGES-2:0], accept};
            done_reg  <= valid_reg[LANE_STAGES-1];
        end
    end

    always_comb
    begin
        visible_next = 1'b1;
        inside_next  = 1'b1;
        for (int i = 0; i < EVAL_PLANES; i++)
        begin
            visible_next = visible_next & ~lane_verdict[i].outside;
            inside_next  = inside_next & lane_verdict[i].enclosed;
        end
    end

    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
        inside_reg  <= inside_next;
    end

    assign done         = done_reg;
    assign visible      = visible_reg;
    assign fully_inside = inside_reg;

    `APSC_ASSERT_SEQ(a_latency, accept, ##4 done, "request did not complete in four cycles")
    `APSC_ASSERT_NOW(a_no_spurious, done, $past(accept, 4), "done without a matching request")
    `APSC_ASSERT_NOW(a_inside_visible, done && fully_inside, visible,
                     "box reported fully inside but not visible")
    `APSC_ASSERT_NEXT(a_stage_flow, valid_reg[LANE_STAGES-1], done,
                      "final stage valid did not raise done")

endmodule
